// ===== rtl/core/kesp_pkg.sv =====
// Shared types and constants of the key event scheduler.
package kesp_pkg;

  // Input commands, carried on the slave tuser
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_CHECK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_NOTES_EN   = 3'd0;
  localparam logic [2:0] CFG_MAX_NOTES  = 3'd1;
  localparam logic [2:0] CFG_VOLUME     = 3'd2;
  localparam logic [2:0] CFG_CEILING    = 3'd3;
  localparam logic [2:0] CFG_FLOOR      = 3'd4;
  localparam logic [2:0] CFG_AUTO_RESET = 3'd5;

  // Configuration reset values
  localparam logic       RST_NOTES_EN   = 1'b1;
  localparam logic [6:0] RST_MAX_NOTES  = 7'd88;
  localparam logic [7:0] RST_VOLUME     = 8'd100;
  localparam logic [7:0] RST_CEILING    = 8'd255;
  localparam logic [7:0] RST_FLOOR      = 8'd0;
  localparam logic [15:0] RST_AUTO_RESET = 16'd0;

  // Volume arithmetic
  localparam logic [7:0]  VOL_UNITY   = 8'd100;
  localparam logic [9:0]  VOL_FULL    = 10'd200;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  // floor(m / 100) = (m * 5243) >> 19 for m below 2^15
  localparam logic [12:0] DIV100_MUL  = 13'd5243;
  localparam int          DIV100_SHR  = 19;
  // floor(x / 127) = (x * 33027) >> 22 for x below 32575
  localparam logic [15:0] DIV127_MUL  = 16'd33027;
  localparam int          DIV127_SHR  = 22;
  localparam logic [14:0] ROUND_HALF  = 15'd63;
  // numerators from here up round to 256 or more
  localparam logic signed [18:0] NUM_SAT = 19'sd32512;
  localparam logic [7:0]  PWM_MAX     = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        notes_en;
    logic [6:0]  max_notes;
    logic [7:0]  volume;
    logic [7:0]  ceiling;
    logic [7:0]  floor_lvl;
    logic [15:0] auto_secs;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  key;
    logic [31:0] now_ms;
    logic [6:0]  pressed_keys;
    logic        planned_in;
    logic        triggered_in;
    logic [31:0] on_time;
    logic [6:0]  on_velocity;
    logic [31:0] off_time;
    logic [31:0] hold_time;
    logic [6:0]  hold_velocity;
  } item_t;

  typedef enum logic [1:0] {
    JOB_NOTE     = 2'd0,
    JOB_ALL_OFF  = 2'd1,
    JOB_DEADLINE = 2'd2
  } job_kind_e;

  // One result to be produced by the back end
  typedef struct packed {
    job_kind_e   kind;
    logic [6:0]  channel;
    logic [6:0]  velocity;
    logic [31:0] now_ms;
    logic        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic        note_valid;
    logic [6:0]  channel;
    logic [7:0]  pwm_value;
    logic        all_off;
    logic        deadline_valid;
    logic [31:0] reset_deadline;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/key_event_scheduler_pwm_core.sv =====
// Top level of the key event scheduler with PWM channel output.
//
//   channel   dir  payload                                    protocol
//   s_axis    in   tuser command, tdata key/time/entry fields  tvalid/tready
//   m_axis    out  tuser kind flags, tdata channel/pwm/time   tvalid/tready/tlast
//   cfg       in   register index and write data               cfg_we_i, no wait
//
// A write is done on accept; a check reads the table, evaluates, then pushes one
// job per result; clear pushes one job, finish one if no keys are pressed; the
// front end handles one request at a time. The back end has two job registers.
// After reset the key table reads as zero through per-key valid bits; no
// clearing pass. A stalled output holds its register; a 4-entry job queue
// lets the front end keep accepting until it fills.
module key_event_scheduler_pwm_core #(
  parameter int KEY_COUNT = 88
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // command request
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: key, now_ms, pressed_keys, planned_in, triggered_in, on_time,
  //        on_velocity, off_time, hold_time, hold_velocity, 2 pad bits
  input  logic [159:0]  s_axis_tdata,
  // tuser: command
  input  logic [1:0]    s_axis_tuser,
  // result request
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: channel, pwm_value, reset_deadline, 1 pad bit
  output logic [47:0]   m_axis_tdata,
  // tuser: note_valid, all_off, deadline_valid
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  // configuration writes
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i
);

  kesp_pkg::cfg_t    cfg_q;
  kesp_pkg::item_t   item;
  kesp_pkg::push_t   push;
  kesp_pkg::job_t    q_job;
  kesp_pkg::result_t res;
  logic              q_full, q_valid, q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.notes_en  <= kesp_pkg::RST_NOTES_EN;
      cfg_q.max_notes <= kesp_pkg::RST_MAX_NOTES;
      cfg_q.volume    <= kesp_pkg::RST_VOLUME;
      cfg_q.ceiling   <= kesp_pkg::RST_CEILING;
      cfg_q.floor_lvl <= kesp_pkg::RST_FLOOR;
      cfg_q.auto_secs <= kesp_pkg::RST_AUTO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kesp_pkg::CFG_NOTES_EN:   cfg_q.notes_en  <= cfg_wdata_i[0];
        kesp_pkg::CFG_MAX_NOTES:  cfg_q.max_notes <= cfg_wdata_i[6:0];
        kesp_pkg::CFG_VOLUME:     cfg_q.volume    <= cfg_wdata_i[7:0];
        kesp_pkg::CFG_CEILING:    cfg_q.ceiling   <= cfg_wdata_i[7:0];
        kesp_pkg::CFG_FLOOR:      cfg_q.floor_lvl <= cfg_wdata_i[7:0];
        kesp_pkg::CFG_AUTO_RESET: cfg_q.auto_secs <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // unpack request fields
  always_comb begin
    item.command       = s_axis_tuser;
    item.key           = s_axis_tdata[6:0];
    item.now_ms        = s_axis_tdata[38:7];
    item.pressed_keys  = s_axis_tdata[45:39];
    item.planned_in    = s_axis_tdata[46];
    item.triggered_in  = s_axis_tdata[47];
    item.on_time       = s_axis_tdata[79:48];
    item.on_velocity   = s_axis_tdata[86:80];
    item.off_time      = s_axis_tdata[118:87];
    item.hold_time     = s_axis_tdata[150:119];
    item.hold_velocity = s_axis_tdata[157:151];
  end

  kesp_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .push_o       (push),
    .q_full_i     (q_full)
  );

  kesp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  kesp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // pack result fields
  assign m_axis_tdata = {1'b0, res.reset_deadline, res.pwm_value, res.channel};
  assign m_axis_tuser = {res.deadline_valid, res.all_off, res.note_valid};
  assign m_axis_tlast = res.last;

endmodule

// ===== rtl/core/kesp_queue.sv =====
// Small job queue between the front end and the back end.
module kesp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kesp_pkg::push_t  push_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output kesp_pkg::job_t   job_o
);

  kesp_pkg::job_t               slots [kesp_pkg::QUEUE_DEPTH];
  logic [kesp_pkg::QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [kesp_pkg::QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [kesp_pkg::QUEUE_AW:0]   count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == (kesp_pkg::QUEUE_AW+1)'(kesp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slots[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ===== rtl/core/kesp_front.sv =====
// Front end: key table, command decode and check evaluation.
module kesp_front #(
  parameter int KEY_COUNT = 88
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kesp_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  kesp_pkg::item_t  item_i,
  output kesp_pkg::push_t  push_o,
  input  logic             q_full_i
);

  localparam int KeyIdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_PUSH0 = 4'b0100,
    ST_PUSH1 = 4'b1000
  } state_e;

  typedef struct packed {
    logic [31:0] strike_time;
    logic [6:0]  strike_vel;
    logic [31:0] release_time;
    logic [31:0] hold_time;
    logic [6:0]  hold_vel;
  } entry_t;

  state_e state_q, state_d;

  // per-key flags; valid marks entries written since reset or clear
  logic [KEY_COUNT-1:0] valid_q, planned_q, triggered_q;
  entry_t               table_mem [KEY_COUNT];
  entry_t               rd_q;
  logic                 rd_valid_q;

  // request captured for the check
  logic [KeyIdxW-1:0] key_q;
  logic [6:0]         chan_q;
  logic [31:0]        now_q;
  logic [6:0]         pressed_q;

  kesp_pkg::job_t job0_q, job0_d, job1_q, job1_d;
  logic           two_q, two_d;

  logic               accept, key_ok;
  logic [KeyIdxW-1:0] in_idx;
  logic [6:0]         in_chan;

  logic               mem_we;
  logic [KeyIdxW-1:0] mem_addr;
  entry_t             mem_wdata;

  // check evaluation
  entry_t      ent;
  logic        pl, tr, strike, tr1, release_hit, hold_hit, room;
  logic [31:0] ht1, ht2;
  logic        emit_s, emit_r, emit_h;
  logic [1:0]  n_res;
  logic [6:0]  vel0, vel1;

  assign item_ready_o = (state_q == ST_IDLE);
  assign accept       = item_valid_i && item_ready_o;
  assign key_ok       = ({1'b0, item_i.key} < 8'(KEY_COUNT));
  assign in_idx       = item_i.key[KeyIdxW-1:0];
  assign in_chan      = 7'(KEY_COUNT - 1) - item_i.key;

  // strike, release and hold decisions for the checked key
  always_comb begin
    ent         = rd_valid_q ? rd_q : '0;
    pl          = planned_q[key_q];
    tr          = triggered_q[key_q];
    strike      = pl && (ent.strike_time < now_q);
    tr1         = strike || tr;
    release_hit = tr1 && (ent.release_time != '0) && (ent.release_time < now_q);
    ht1         = release_hit ? '0 : ent.hold_time;
    hold_hit    = (ht1 != '0) && (ht1 < now_q);
    ht2         = hold_hit ? '0 : ht1;
    room        = (pressed_q < cfg_i.max_notes);
    emit_s      = strike && cfg_i.notes_en && ((ent.strike_vel == '0) || room);
    emit_r      = release_hit && cfg_i.notes_en;
    emit_h      = hold_hit && cfg_i.notes_en && ((ent.hold_vel == '0) || room)
                  && !(emit_s && emit_r);
    n_res       = 2'(emit_s) + 2'(emit_r) + 2'(emit_h);
    vel0        = emit_s ? ent.strike_vel : (emit_r ? 7'd0 : ent.hold_vel);
    vel1        = (emit_s && emit_r) ? 7'd0 : ent.hold_vel;
  end

  // table write port: entry load or check write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = in_idx;
    mem_wdata = '{strike_time:  item_i.on_time,
                  strike_vel:   item_i.on_velocity,
                  release_time: item_i.off_time,
                  hold_time:    item_i.hold_time,
                  hold_vel:     item_i.hold_velocity};
    if (state_q == ST_CHECK) begin
      mem_we              = 1'b1;
      mem_addr            = key_q;
      mem_wdata           = ent;
      mem_wdata.hold_time = ht2;
    end else if (accept && (item_i.command == kesp_pkg::CMD_WRITE) && key_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= table_mem[in_idx];
    end
  end

  // sequencer and queued jobs
  always_comb begin
    state_d    = state_q;
    job0_d     = job0_q;
    job1_d     = job1_q;
    two_d      = two_q;
    push_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.command)
            kesp_pkg::CMD_CHECK: begin
              if (key_ok) state_d = ST_CHECK;
            end
            kesp_pkg::CMD_CLEAR: begin
              job0_d      = '0;
              job0_d.kind = kesp_pkg::JOB_ALL_OFF;
              job0_d.last = 1'b1;
              two_d       = 1'b0;
              state_d     = ST_PUSH0;
            end
            kesp_pkg::CMD_FINISH: begin
              if (item_i.pressed_keys == '0) begin
                job0_d        = '0;
                job0_d.kind   = kesp_pkg::JOB_DEADLINE;
                job0_d.now_ms = item_i.now_ms;
                job0_d.last   = 1'b1;
                two_d         = 1'b0;
                state_d       = ST_PUSH0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        job0_d = '{kind: kesp_pkg::JOB_NOTE, channel: chan_q, velocity: vel0,
                   now_ms: now_q, last: (n_res == 2'd1)};
        job1_d = '{kind: kesp_pkg::JOB_NOTE, channel: chan_q, velocity: vel1,
                   now_ms: now_q, last: 1'b1};
        two_d  = (n_res == 2'd2);
        state_d = (n_res == 2'd0) ? ST_IDLE : ST_PUSH0;
      end
      ST_PUSH0: begin
        push_o.valid = 1'b1;
        push_o.job   = job0_q;
        if (!q_full_i) state_d = two_q ? ST_PUSH1 : ST_IDLE;
      end
      ST_PUSH1: begin
        push_o.valid = 1'b1;
        push_o.job   = job1_q;
        if (!q_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      planned_q   <= '0;
      triggered_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_valid_q <= valid_q[in_idx];
      end
      if (state_q == ST_CHECK) begin
        valid_q[key_q]     <= 1'b1;
        planned_q[key_q]   <= pl && !strike;
        triggered_q[key_q] <= tr1 && !release_hit;
      end else if (accept && key_ok && (item_i.command == kesp_pkg::CMD_WRITE)) begin
        valid_q[in_idx]     <= 1'b1;
        planned_q[in_idx]   <= item_i.planned_in;
        triggered_q[in_idx] <= item_i.triggered_in;
      end else if (accept && (item_i.command == kesp_pkg::CMD_CLEAR)) begin
        valid_q     <= '0;
        planned_q   <= '0;
        triggered_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job0_q <= job0_d;
    job1_q <= job1_d;
    two_q  <= two_d;
    if (accept) begin
      key_q     <= in_idx;
      chan_q    <= in_chan;
      now_q     <= item_i.now_ms;
      pressed_q <= item_i.pressed_keys;
    end
  end

endmodule

// ===== rtl/core/kesp_back.sv =====
// Back end: velocity scaling, deadline arithmetic and output register.
module kesp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kesp_pkg::cfg_t    cfg_i,
  input  logic              job_valid_i,
  input  kesp_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output kesp_pkg::result_t res_o
);

  // ---- PWM window, recomputed from configuration every cycle ----
  logic signed [8:0]  span;
  logic signed [9:0]  vsel;
  logic signed [18:0] span_x, vsel_x, wprod_d, wprod_q;
  logic               wneg;
  logic [18:0]        wmag;
  logic [27:0]        wdiv;
  logic [8:0]         wq;
  logic signed [9:0]  range_div, range_d, range_q;
  logic signed [10:0] ceil_x, floor_x, range_x, base_d, base_q;
  logic               vol_lt, vol_gt;

  always_comb begin
    span    = $signed({1'b0, cfg_i.ceiling}) - $signed({1'b0, cfg_i.floor_lvl});
    vol_lt  = (cfg_i.volume < kesp_pkg::VOL_UNITY);
    vol_gt  = (cfg_i.volume > kesp_pkg::VOL_UNITY);
    vsel    = vol_lt ? $signed({2'b00, cfg_i.volume})
                     : $signed(kesp_pkg::VOL_FULL) - $signed({2'b00, cfg_i.volume});
    span_x  = 19'(span);
    vsel_x  = 19'(vsel);
    wprod_d = span_x * vsel_x;
  end

  // signed divide by 100, truncating toward zero
  always_comb begin
    wneg      = wprod_q[18];
    wmag      = wneg ? 19'(-wprod_q) : 19'(wprod_q);
    wdiv      = 28'(wmag[14:0]) * 28'(kesp_pkg::DIV100_MUL);
    wq        = wdiv[27:kesp_pkg::DIV100_SHR];
    range_div = wneg ? -$signed({1'b0, wq}) : $signed({1'b0, wq});
    range_d   = (vol_lt || vol_gt) ? range_div : 10'(span);
    ceil_x    = $signed({3'b000, cfg_i.ceiling});
    floor_x   = $signed({3'b000, cfg_i.floor_lvl});
    range_x   = 11'(range_d);
    base_d    = vol_gt ? (ceil_x - range_x) : floor_x;
  end

  always_ff @(posedge clk_i) begin
    wprod_q <= wprod_d;
    range_q <= range_d;
    base_q  <= base_d;
  end

  // ---- stage 1: numerator or deadline offset ----
  logic               s1_v_q;
  kesp_pkg::job_t     s1_job_q;
  logic signed [18:0] num_d, num_q;
  logic [25:0]        dofs_d, dofs_q;
  logic signed [18:0] vel_x, rng_x, base_x;
  logic               out_adv, s1_adv;

  always_comb begin
    vel_x  = $signed({12'd0, job_i.velocity});
    rng_x  = 19'(range_q);
    base_x = 19'(base_q);
    num_d  = vel_x * rng_x + (base_x <<< 7) - base_x;
    dofs_d = 26'(cfg_i.auto_secs) * 26'(kesp_pkg::MS_PER_SEC);
  end

  // ---- stage 2: rounding divide by 127 and saturation ----
  logic [14:0] rnd_x;
  logic [30:0] rnd_p;
  logic [8:0]  rnd_q;
  logic [7:0]  pwm;
  kesp_pkg::result_t res_d, res_q;
  logic        out_v_q;

  always_comb begin
    rnd_x = num_q[14:0] + kesp_pkg::ROUND_HALF;
    rnd_p = 31'(rnd_x) * 31'(kesp_pkg::DIV127_MUL);
    rnd_q = rnd_p[30:kesp_pkg::DIV127_SHR];
    if (s1_job_q.velocity == '0 || num_q[18]) begin
      pwm = '0;
    end else if (num_q >= kesp_pkg::NUM_SAT || rnd_q[8]) begin
      pwm = kesp_pkg::PWM_MAX;
    end else begin
      pwm = rnd_q[7:0];
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.last = s1_job_q.last;
    case (s1_job_q.kind)
      kesp_pkg::JOB_NOTE: begin
        res_d.note_valid = 1'b1;
        res_d.channel    = s1_job_q.channel;
        res_d.pwm_value  = pwm;
      end
      kesp_pkg::JOB_ALL_OFF: begin
        res_d.all_off = 1'b1;
      end
      kesp_pkg::JOB_DEADLINE: begin
        res_d.deadline_valid = 1'b1;
        res_d.reset_deadline = s1_job_q.now_ms + 32'(dofs_q);
      end
      default: ;
    endcase
  end

  // pipeline flow
  assign out_adv     = !out_v_q || res_ready_i;
  assign s1_adv      = !s1_v_q || out_adv;
  assign pop_o       = job_valid_i && s1_adv;
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= job_valid_i;
      if (out_adv) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_job_q <= job_i;
      num_q    <= num_d;
      dofs_q   <= dofs_d;
    end
    if (out_adv && s1_v_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== tb/tb_key_event_scheduler_pwm_core.sv =====
// Testbench of the key event scheduler: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_key_event_scheduler_pwm_core;

  localparam int KEYS          = 88;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // tdata: key, now_ms, pressed_keys, planned_in, triggered_in, on_time,
  //        on_velocity, off_time, hold_time, hold_velocity, 2 pad bits
  logic [159:0]  s_axis_tdata;
  // tuser: command
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // tdata: channel, pwm_value, reset_deadline, 1 pad bit
  logic [47:0]   m_axis_tdata;
  // tuser: note_valid, all_off, deadline_valid
  logic [2:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          cfg_we_i;
  logic [2:0]    cfg_idx_i;
  logic [15:0]   cfg_wdata_i;

  key_event_scheduler_pwm_core #(
    .KEY_COUNT(KEYS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predictor state: key table and register copy
  logic           armed      [KEYS];
  logic           sounding   [KEYS];
  logic [31:0]    strike_at  [KEYS];
  logic [6:0]     strike_vel [KEYS];
  logic [31:0]    release_at [KEYS];
  logic [31:0]    hold_at    [KEYS];
  logic [6:0]     hold_vel   [KEYS];
  kesp_pkg::cfg_t regs;

  kesp_pkg::result_t awaited_updates[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct;
  int          ready_stall_pct;
  logic [31:0] clock_ms;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Velocity into the PWM window, rounded half away from zero, then clamped
  function automatic logic [7:0] scaled_pwm(logic [6:0] vel);
    int span, vol, win, lo, num, q;
    span = int'(regs.ceiling) - int'(regs.floor_lvl);
    vol  = int'(regs.volume);
    if (vol < 100) begin
      win = span * vol / 100;
      lo  = int'(regs.floor_lvl);
    end else if (vol > 100) begin
      win = span * (200 - vol) / 100;
      lo  = int'(regs.ceiling) - win;
    end else begin
      win = span;
      lo  = int'(regs.floor_lvl);
    end
    num = int'(vel) * win + 127 * lo;
    if (num >= 0) q = (num + 63) / 127;
    else q = -((-num + 63) / 127);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Whether a channel setting goes out; zero velocity always passes the note limit
  function automatic bit channel_setting(logic [6:0] vel, logic [6:0] pressed,
                                         output logic [7:0] pwm);
    pwm = '0;
    if (!regs.notes_en) return 1'b0;
    if (vel != 0) begin
      if (pressed >= regs.max_notes) return 1'b0;
      pwm = scaled_pwm(vel);
    end
    return 1'b1;
  endfunction

  function automatic kesp_pkg::result_t note_update(int ch, logic [7:0] pwm);
    kesp_pkg::result_t r;
    r = '0;
    r.note_valid = 1'b1;
    r.channel    = ch[6:0];
    r.pwm_value  = pwm;
    return r;
  endfunction

  // Advance the key table by one request and queue the updates it causes
  function automatic void apply_to_key_table(kesp_pkg::item_t it);
    kesp_pkg::result_t batch[$];
    kesp_pkg::result_t r;
    logic [7:0]  pwm;
    int          k, ch;
    k = int'(it.key);
    case (it.command)
      kesp_pkg::CMD_WRITE: begin
        if (k < KEYS) begin
          armed[k]      = it.planned_in;
          sounding[k]   = it.triggered_in;
          strike_at[k]  = it.on_time;
          strike_vel[k] = it.on_velocity;
          release_at[k] = it.off_time;
          hold_at[k]    = it.hold_time;
          hold_vel[k]   = it.hold_velocity;
        end
      end
      kesp_pkg::CMD_CHECK: begin
        if (k < KEYS) begin
          ch = KEYS - 1 - k;
          // strike
          if (armed[k] && strike_at[k] < it.now_ms) begin
            if (channel_setting(strike_vel[k], it.pressed_keys, pwm))
              batch.push_back(note_update(ch, pwm));
            armed[k]    = 1'b0;
            sounding[k] = 1'b1;
          end
          // release also cancels a pending hold
          if (sounding[k] && release_at[k] != 0 && release_at[k] < it.now_ms) begin
            if (channel_setting(7'd0, it.pressed_keys, pwm))
              batch.push_back(note_update(ch, pwm));
            hold_at[k]  = '0;
            sounding[k] = 1'b0;
          end
          // drop to hold level
          if (hold_at[k] != 0 && hold_at[k] < it.now_ms) begin
            if (batch.size() < 2 && channel_setting(hold_vel[k], it.pressed_keys, pwm))
              batch.push_back(note_update(ch, pwm));
            hold_at[k] = '0;
          end
        end
      end
      kesp_pkg::CMD_CLEAR: begin
        for (int i = 0; i < KEYS; i++) begin
          armed[i]      = 1'b0;
          sounding[i]   = 1'b0;
          strike_at[i]  = '0;
          strike_vel[i] = '0;
          release_at[i] = '0;
          hold_at[i]    = '0;
          hold_vel[i]   = '0;
        end
        r = '0;
        r.all_off = 1'b1;
        batch.push_back(r);
      end
      default: begin
        if (it.pressed_keys == 0) begin
          r = '0;
          r.deadline_valid = 1'b1;
          r.reset_deadline = it.now_ms + 32'(regs.auto_secs) * 32'd1000;
          batch.push_back(r);
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_updates.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and field compare
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    kesp_pkg::result_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_updates.size() == 0) begin
          $error("result request with no update outstanding");
          error_count++;
        end else begin
          exp = awaited_updates.pop_front();
          compare_field("note_valid", 32'(exp.note_valid), 32'(m_axis_tuser[0]));
          compare_field("channel", 32'(exp.channel), 32'(m_axis_tdata[6:0]));
          compare_field("pwm_value", 32'(exp.pwm_value), 32'(m_axis_tdata[14:7]));
          compare_field("all_off", 32'(exp.all_off), 32'(m_axis_tuser[1]));
          compare_field("deadline_valid", 32'(exp.deadline_valid), 32'(m_axis_tuser[2]));
          compare_field("reset_deadline", exp.reset_deadline, m_axis_tdata[46:15]);
          compare_field("last", 32'(exp.last), 32'(m_axis_tlast));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Idle until a random draw passes, then present one request until taken
  task automatic send_item(kesp_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.command;
    s_axis_tdata  <= {2'b00, it.hold_velocity, it.hold_time, it.off_time, it.on_velocity,
                      it.on_time, it.triggered_in, it.planned_in, it.pressed_keys,
                      it.now_ms, it.key};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_to_key_table(it);
  endtask

  // Stop sending and wait until every update is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kesp_pkg::CFG_NOTES_EN:   regs.notes_en  = val[0];
      kesp_pkg::CFG_MAX_NOTES:  regs.max_notes = val[6:0];
      kesp_pkg::CFG_VOLUME:     regs.volume    = val[7:0];
      kesp_pkg::CFG_CEILING:    regs.ceiling   = val[7:0];
      kesp_pkg::CFG_FLOOR:      regs.floor_lvl = val[7:0];
      kesp_pkg::CFG_AUTO_RESET: regs.auto_secs = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(kesp_pkg::cfg_t c);
    wait_idle();
    write_reg(kesp_pkg::CFG_NOTES_EN, 16'(c.notes_en));
    write_reg(kesp_pkg::CFG_MAX_NOTES, 16'(c.max_notes));
    write_reg(kesp_pkg::CFG_VOLUME, 16'(c.volume));
    write_reg(kesp_pkg::CFG_CEILING, 16'(c.ceiling));
    write_reg(kesp_pkg::CFG_FLOOR, 16'(c.floor_lvl));
    write_reg(kesp_pkg::CFG_AUTO_RESET, c.auto_secs);
  endtask

  function automatic kesp_pkg::item_t entry(logic [6:0] key, logic planned, logic triggered,
                                  logic [31:0] on_t, logic [6:0] on_v, logic [31:0] off_t,
                                  logic [31:0] hold_t, logic [6:0] hold_v);
    kesp_pkg::item_t it;
    it = '0;
    it.command       = kesp_pkg::CMD_WRITE;
    it.key           = key;
    it.planned_in    = planned;
    it.triggered_in  = triggered;
    it.on_time       = on_t;
    it.on_velocity   = on_v;
    it.off_time      = off_t;
    it.hold_time     = hold_t;
    it.hold_velocity = hold_v;
    return it;
  endfunction

  function automatic kesp_pkg::item_t probe(logic [1:0] cmd, logic [6:0] key,
                                            logic [31:0] now, logic [6:0] pressed);
    kesp_pkg::item_t it;
    it = '0;
    it.command      = cmd;
    it.key          = key;
    it.now_ms       = now;
    it.pressed_keys = pressed;
    return it;
  endfunction

  // Mostly a few busy keys so entries get struck, released and held
  function automatic logic [6:0] pick_key();
    int hot;
    if ($urandom_range(99) < 80) begin
      hot = $urandom_range(0, 7);
      return (hot < 6) ? 7'(hot) : 7'(80 + hot);
    end
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [6:0] pick_pressed();
    if ($urandom_range(99) < 70) return 7'($urandom_range(0, 8));
    return 7'($urandom_range(0, 127));
  endfunction

  // Well-formed schedules against a running clock, plus some raw noise
  function automatic kesp_pkg::item_t next_item();
    kesp_pkg::item_t it;
    int    roll;
    roll = $urandom_range(99);
    it = probe(kesp_pkg::CMD_CHECK, pick_key(), clock_ms, pick_pressed());
    if (roll < 35) begin
      it = entry(pick_key(), $urandom_range(99) < 75, $urandom_range(99) < 25,
                 clock_ms + $urandom_range(0, 40), 7'($urandom_range(0, 127)), '0, '0,
                 7'($urandom_range(0, 127)));
      if ($urandom_range(3) != 0) it.off_time = it.on_time + $urandom_range(1, 60);
      if ($urandom_range(2) != 0) it.hold_time = it.on_time + $urandom_range(0, 80);
      it.now_ms = $urandom;
      it.pressed_keys = 7'($urandom_range(0, 127));
    end else if (roll < 80) begin
      clock_ms  = clock_ms + $urandom_range(0, 30);
      it.now_ms = clock_ms;
    end else if (roll < 86) begin
      it.command = kesp_pkg::CMD_FINISH;
      if ($urandom_range(1) == 0) it.pressed_keys = '0;
    end else if (roll < 89) begin
      it.command = kesp_pkg::CMD_CLEAR;
    end else begin
      it.command       = 2'($urandom_range(0, 3));
      it.key           = 7'($urandom_range(0, 127));
      it.now_ms        = $urandom;
      it.pressed_keys  = 7'($urandom_range(0, 127));
      it.planned_in    = 1'($urandom_range(0, 1));
      it.triggered_in  = 1'($urandom_range(0, 1));
      it.on_time       = $urandom;
      it.on_velocity   = 7'($urandom_range(0, 127));
      it.off_time      = $urandom;
      it.hold_time     = $urandom;
      it.hold_velocity = 7'($urandom_range(0, 127));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state: empty table, zero auto-reset offset
  task automatic test_after_reset();
    send_item(probe(kesp_pkg::CMD_FINISH, 7'd0, 32'h1234_5678, 7'd0));
    send_item(probe(kesp_pkg::CMD_FINISH, 7'd0, 32'h1234_5678, 7'd1));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd0, 32'hFFFF_FFFF, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd87, 32'hFFFF_FFFF, 7'd0));
    send_item(probe(kesp_pkg::CMD_CLEAR, 7'd0, 32'd0, 7'd0));
  endtask

  // Strike, release and hold paths and their corner cases at default settings
  task automatic test_note_paths();
    // strike fires only once now passes the strike time
    send_item(entry(7'd0, 1'b1, 1'b0, 32'd100, 7'd127, 32'd0, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd0, 32'd100, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd0, 32'd101, 7'd0));
    // strike and hold in one check
    send_item(entry(7'd87, 1'b1, 1'b0, 32'd10, 7'd1, 32'd0, 32'd20, 7'd64));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd87, 32'd50, 7'd0));
    // strike then release, which cancels the hold
    send_item(entry(7'd1, 1'b1, 1'b0, 32'd5, 7'd90, 32'd6, 32'd7, 7'd50));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd1, 32'd100, 7'd3));
    // release alone goes out even with the note limit reached
    send_item(entry(7'd2, 1'b0, 1'b1, 32'd0, 7'd0, 32'd1, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd2, 32'd2, 7'd88));
    // note limit drops the strike but the entry still advances
    send_item(entry(7'd3, 1'b1, 1'b0, 32'd0, 7'd64, 32'd0, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd3, 32'd1, 7'd88));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd3, 32'd5, 7'd0));
    // keys past the table are ignored
    send_item(entry(7'd88, 1'b1, 1'b0, 32'd0, 7'd10, 32'd0, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd88, 32'd9, 7'd0));
    send_item(entry(7'd127, 1'b1, 1'b1, 32'd0, 7'd127, 32'd1, 32'd1, 7'd127));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd127, 32'hFFFF_FFFF, 7'd0));
    // zero velocity at the top of time
    send_item(entry(7'd4, 1'b1, 1'b0, 32'hFFFF_FFFE, 7'd0, 32'd0, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd4, 32'hFFFF_FFFF, 7'd127));
    send_item(probe(kesp_pkg::CMD_FINISH, 7'd0, 32'hFFFF_FFFF, 7'd0));
    send_item(probe(kesp_pkg::CMD_CLEAR, 7'd0, 32'd0, 7'd0));
    send_item(probe(kesp_pkg::CMD_CHECK, 7'd87, 32'hFFFF_FFFF, 7'd0));
  endtask

  // Register settings including extremes, each with a scaled note and traffic
  task automatic test_settings();
    kesp_pkg::cfg_t presets [10] = '{
      '{1'b1, 7'd88,  8'd100, 8'd255, 8'd0,   16'd0},
      '{1'b0, 7'd88,  8'd100, 8'd255, 8'd0,   16'd1},
      '{1'b1, 7'd0,   8'd50,  8'd200, 8'd40,  16'd65535},
      '{1'b1, 7'd127, 8'd0,   8'd255, 8'd0,   16'd1000},
      '{1'b1, 7'd10,  8'd150, 8'd255, 8'd0,   16'd7},
      '{1'b1, 7'd88,  8'd200, 8'd100, 8'd20,  16'd65535},
      '{1'b1, 7'd88,  8'd255, 8'd255, 8'd255, 16'd3},
      '{1'b1, 7'd88,  8'd73,  8'd0,   8'd255, 16'd0},
      '{1'b1, 7'd88,  8'd120, 8'd30,  8'd200, 16'd42},
      '{1'b1, 7'd5,   8'd100, 8'd0,   8'd0,   16'd12345}
    };
    foreach (presets[p]) begin
      apply_config(presets[p]);
      send_idle_pct   = (p % 2) ? 33 : 0;
      ready_stall_pct = (p % 3) ? 33 : 0;
      clock_ms = $urandom_range(0, 1000000);
      send_item(entry(7'd5, 1'b1, 1'b0, clock_ms, 7'($urandom_range(1, 127)), 32'd0,
                      clock_ms + 1, 7'($urandom_range(1, 127))));
      send_item(probe(kesp_pkg::CMD_CHECK, 7'd5, clock_ms + 10, 7'd2));
      send_item(probe(kesp_pkg::CMD_FINISH, 7'd0, $urandom, 7'd0));
      repeat (40) send_item(next_item());
    end
  endtask

  // Bulk random traffic under each idling pattern
  task automatic test_random_traffic();
    kesp_pkg::cfg_t c;
    for (int phase = 0; phase < 4; phase++) begin
      c = '{kesp_pkg::RST_NOTES_EN, kesp_pkg::RST_MAX_NOTES, kesp_pkg::RST_VOLUME,
            kesp_pkg::RST_CEILING, kesp_pkg::RST_FLOOR, kesp_pkg::RST_AUTO_RESET};
      if (phase != 0) begin
        c.notes_en  = ($urandom_range(9) != 0);
        c.max_notes = ($urandom_range(1) == 0) ? 7'd88 : 7'($urandom_range(0, 127));
        c.volume    = 8'($urandom_range(0, 255));
        c.ceiling   = 8'($urandom_range(0, 255));
        c.floor_lvl = 8'($urandom_range(0, 255));
        c.auto_secs = 16'($urandom_range(0, 65535));
      end
      apply_config(c);
      case (phase)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 46; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 46; end
        default: begin send_idle_pct = 33; ready_stall_pct = 33; end
      endcase
      clock_ms = (phase == 3) ? 32'hFFFF_F000 : $urandom;
      for (int n = 0; n < 400; n++) begin
        send_item(next_item());
        // hold off until the pipe is empty now and then
        if (n % 150 == 149) wait_idle();
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = kesp_pkg::CMD_WRITE;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = kesp_pkg::CFG_NOTES_EN;
    cfg_wdata_i     = '0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    clock_ms        = '0;
    regs = '{kesp_pkg::RST_NOTES_EN, kesp_pkg::RST_MAX_NOTES, kesp_pkg::RST_VOLUME,
             kesp_pkg::RST_CEILING, kesp_pkg::RST_FLOOR, kesp_pkg::RST_AUTO_RESET};
    for (int i = 0; i < KEYS; i++) begin
      armed[i]      = 1'b0;
      sounding[i]   = 1'b0;
      strike_at[i]  = '0;
      strike_vel[i] = '0;
      release_at[i] = '0;
      hold_at[i]    = '0;
      hold_vel[i]   = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_note_paths();
    test_settings();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
